// ----- rtl/complex_arithmetic_unit_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CAU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");
// Property that must hold on every clock edge, reset included.
`define CAU_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");
`endif

// ----- rtl/cau_pkg.sv -----
// Package with operation codes and default widths for the complex arithmetic unit.
package cau_pkg;
  localparam int DefDataWidth = 16;
  localparam int DefFracBits  = 8;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;
endpackage

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider: one quotient bit per stage.
module cau_div import cau_pkg::*; #(
  parameter int NW = 34,
  parameter int DW = 33,
  parameter int QW = 24,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  // Stage s holds remainder (DW+1 bits), remaining numerator bits, quotient.
  logic [DW:0]   rem  [QW+1];
  logic [NW-1:0] nr   [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [DW-1:0] dn   [QW+1];
  logic [TW-1:0] tg   [QW+1];
  logic          v    [QW+1];
  logic [NW-1:0] hi;

  // Align numerator: the top NW-QW bits sit below den, since the quotient fits QW bits.
  assign hi = num >> QW;
  always_comb begin
    rem[0] = '0;
    rem[0][NW-QW-1:0] = hi[NW-QW-1:0];
    nr[0] = num << (NW - QW);
    q[0]  = '0;
    dn[0] = den;
    tg[0] = tag_in;
    v[0]  = in_vld;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rem[s], nr[s][NW-1]};
    assign df = sh - {2'b00, dn[s]};
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (adv) v[s+1] <= v[s];
      if (adv) begin
        rem[s+1] <= df[DW+1] ? sh[DW:0] : df[DW:0];
        q[s+1]   <= {q[s][QW-2:0], ~df[DW+1]};
        nr[s+1]  <= nr[s] << 1;
        dn[s+1]  <= dn[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_vld = v[QW];
  assign quo     = q[QW];
  assign tag_out = tg[QW];
endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------------------
//  input   | in_valid   | in_stall   | mode, a_real, a_imag, b_real, b_imag
//  output  | out_valid  | out_stall  | result_real, result_imag, overflow,
//          |            |            | divide_by_zero
//
// One word enters per cycle while in_stall is low. Every word travels through the operand,
// product and combine registers, the bit-per-stage divider pipeline and the output register.
// The whole pipeline advances together; out_stall holds every stage only while the output
// register is full, and in_stall is raised exactly when the output register is full and held.
// Reset clears only the valid bits.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int FRAC_BITS  = DefFracBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] result_real,
  output logic signed [DATA_WIDTH-1:0] result_imag,
  output logic                         overflow,
  output logic                         divide_by_zero
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;           // one product
  localparam int SW = 2 * W + 1;       // signed sum of two products
  localparam int DW = 2 * W + 1;       // divisor magnitude
  // A quotient magnitude stays below 2^(W-1) * sqrt(2) * 2^FRAC_BITS.
  localparam int QW = W + FRAC_BITS;
  localparam int NW = SW - 1 + FRAC_BITS;  // numerator magnitude scaled
  localparam int TW = 4 + 2 * (W + 1);    // op, dz, signs, pass-through results

  // Advance the whole pipe unless the output word is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: register operands.
  logic        v1;
  op_t         op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      op1 <= op_t'(mode);
      ar1 <= a_real; ai1 <= a_imag; br1 <= b_real; bi1 <= b_imag;
    end
  end

  // Stage 2: four products, sums, divisor squares.
  logic        v2;
  op_t         op2;
  logic signed [PW-1:0] pac, pbd, pad, pbc, pcc, pdd;
  logic signed [W:0]    sre, sim;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      op2 <= op1;
      pac <= ar1 * br1; pbd <= ai1 * bi1;
      pad <= ar1 * bi1; pbc <= ai1 * br1;
      pcc <= br1 * br1; pdd <= bi1 * bi1;
      sre <= (op1 == OP_SUB) ? (W+1)'(ar1) - (W+1)'(br1) : (W+1)'(ar1) + (W+1)'(br1);
      sim <= (op1 == OP_SUB) ? (W+1)'(ai1) - (W+1)'(bi1) : (W+1)'(ai1) + (W+1)'(bi1);
    end
  end

  // Stage 3: combine products into numerators and divisor.
  logic        v3;
  op_t         op3;
  logic signed [SW-1:0] nre, nim;
  logic [DW-1:0]        den3;
  logic signed [W:0]    sre3, sim3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      op3  <= op2;
      sre3 <= sre; sim3 <= sim;
      if (op2 == OP_MUL) begin
        nre <= SW'(pac) - SW'(pbd);
        nim <= SW'(pad) + SW'(pbc);
      end else begin
        nre <= SW'(pac) + SW'(pbd);
        nim <= SW'(pbc) - SW'(pad);
      end
      den3 <= DW'($unsigned(pcc)) + DW'($unsigned(pdd));
    end
  end

  // Saturate a signed wide value to W bits.
  function automatic logic [W:0] sat(input logic signed [SW:0] x);
    logic signed [SW:0] mx, mn;
    mx = (SW+1)'((64'sd1 <<< (W - 1)) - 1);
    mn = -(SW+1)'(64'sd1 <<< (W - 1));
    if (x > mx) sat = {1'b1, mx[W-1:0]};
    else if (x < mn) sat = {1'b1, mn[W-1:0]};
    else sat = {1'b0, x[W-1:0]};
  endfunction

  // Magnitudes and signs of the numerators enter the dividers; other modes ride the tag.
  logic [SW-2:0] mre, mim;
  logic          gre, gim, dz3;
  logic [W:0]    ps_re, ps_im;
  logic [SW:0]   tre, tim;
  assign gre = nre[SW-1];
  assign gim = nim[SW-1];
  assign mre = gre ? (SW-1)'(-nre) : nre[SW-2:0];
  assign mim = gim ? (SW-1)'(-nim) : nim[SW-2:0];
  assign dz3 = (op3 == OP_DIV) && (den3 == '0);
  // Product parts truncate toward zero: shift the magnitude.
  assign tre = gre ? -(SW+1)'(mre >> FRAC_BITS) : (SW+1)'(mre >> FRAC_BITS);
  assign tim = gim ? -(SW+1)'(mim >> FRAC_BITS) : (SW+1)'(mim >> FRAC_BITS);
  always_comb begin
    case (op3)
      OP_MUL: begin
        ps_re = sat(tre);
        ps_im = sat(tim);
      end
      OP_DIV: begin
        ps_re = '0;
        ps_im = '0;
      end
      default: begin
        ps_re = sat((SW+1)'(sre3));
        ps_im = sat((SW+1)'(sim3));
      end
    endcase
  end

  logic [TW-1:0] tgr, tgi;
  logic [DW-1:0] dsafe;
  assign dsafe = dz3 ? DW'(1) : den3;

  logic          vq, vq2;
  logic [QW-1:0] qre, qim;
  logic [NW-1:0] nre_s, nim_s;
  assign nre_s = NW'(mre) << FRAC_BITS;
  assign nim_s = NW'(mim) << FRAC_BITS;

  // Pass-through fields packed next to control bits.
  logic [TW-1:0] tagp;
  assign tagp = {op3 == OP_DIV, dz3, gre, gim, (TW-4)'({ps_re, ps_im})};

  cau_div #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_div_re (
    .clk, .rst, .adv, .in_vld(v3), .num(nre_s), .den(dsafe), .tag_in(tagp),
    .out_vld(vq), .quo(qre), .tag_out(tgr)
  );
  cau_div #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_div_im (
    .clk, .rst, .adv, .in_vld(v3), .num(nim_s), .den(dsafe), .tag_in(tagp),
    .out_vld(vq2), .quo(qim), .tag_out(tgi)
  );

  // Final stage: saturate quotients and register the output word.
  logic [W:0] qs_re, qs_im, fre, fim;
  logic [2*W+1:0] psd;
  logic [SW:0] xre, xim;
  assign psd = tgr[2*W+1:0];
  // The full quotient magnitude fits QW bits; apply the sign, then saturate.
  assign xre = tgr[TW-3] ? -(SW+1)'(qre) : (SW+1)'(qre);
  assign xim = tgr[TW-4] ? -(SW+1)'(qim) : (SW+1)'(qim);
  assign qs_re = sat(xre);
  assign qs_im = sat(xim);
  always_comb begin
    if (tgr[TW-1] && !tgr[TW-2]) begin
      fre = qs_re;
      fim = qs_im;
    end else begin
      fre = psd[2*W+1:W+1];
      fim = psd[W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vq && vq2;
    if (adv) begin
      result_real    <= fre[W-1:0];
      result_imag    <= fim[W-1:0];
      overflow       <= fre[W] | fim[W];
      divide_by_zero <= tgr[TW-2] | (tgi[TW-2] & 1'b0);
    end
  end
endmodule

// ----- rtl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit, bound to the top level.
`include "complex_arithmetic_unit_macros.svh"
module cau_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic overflow,
  input logic divide_by_zero
);
  `CAU_ASSERT(a_stall_only_when_held, clk, rst, in_stall |-> (out_valid && out_stall))
  `CAU_ASSERT(a_out_holds, clk, rst, (out_valid && out_stall) |=> out_valid)
  `CAU_ASSERT(a_dz_no_ovf, clk, rst, (out_valid && divide_by_zero) |-> !overflow)
  `CAU_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .overflow, .divide_by_zero
);

// ----- tb/cau_checker.sv -----
// Checker for the complex arithmetic unit: predicts each result word and compares it.
module cau_scoreboard import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] result_real,
  input  logic signed [15:0] result_imag,
  input  logic               overflow,
  input  logic               divide_by_zero,
  output int                 errors,
  output int                 pending,
  output int                 accepted_out
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               ovf;
    logic               dz;
  } cplx_res_t;

  cplx_res_t expected_results[$];

  localparam longint MaxPart = 32767;
  localparam longint MinPart = -32768;

  function automatic logic signed [15:0] clamp16(longint v, ref logic ovf);
    if (v > MaxPart) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < MinPart) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Truncate toward zero: divide magnitudes and reapply the sign.
  function automatic longint trunc_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = mag / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic cplx_res_t compute_complex(op_t op, longint a, longint b,
                                                longint c, longint d);
    cplx_res_t r;
    logic      ovf;
    longint    den;
    ovf = 1'b0;
    r   = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp16(a + c, ovf);
        r.im = clamp16(b + d, ovf);
      end
      OP_SUB: begin
        r.re = clamp16(a - c, ovf);
        r.im = clamp16(b - d, ovf);
      end
      OP_MUL: begin
        r.re = clamp16(trunc_div(a * c - b * d, 256), ovf);
        r.im = clamp16(trunc_div(a * d + b * c, 256), ovf);
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = clamp16(trunc_div((a * c + b * d) * 256, den), ovf);
          r.im = clamp16(trunc_div((b * c - a * d) * 256, den), ovf);
        end
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (rst) begin
      errors       <= 0;
      accepted_out <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(compute_complex(op_t'(mode), a_real, a_imag,
                                                   b_real, b_imag));
      if (out_valid && !out_stall) begin
        accepted_out <= accepted_out + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: re=%0d im=%0d", $time,
                   result_real, result_imag);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.re !== result_real || exp_r.im !== result_imag ||
              exp_r.ovf !== overflow || exp_r.dz !== divide_by_zero) begin
            $display("%0t: mismatch expected re=%0d im=%0d ovf=%0b dz=%0b", $time,
                     exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz);
            $display("%0t:          actual   re=%0d im=%0d ovf=%0b dz=%0b", $time,
                     result_real, result_imag, overflow, divide_by_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the complex arithmetic unit: stimulus, stalls and the verdict.
module tb_top import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 4 + DefDataWidth + DefFracBits;
  localparam int Watchdog  = 2000;
  localparam int NumRandom = 750;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = OP_ADD;
  logic signed [15:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] result_real, result_imag;
  logic               overflow, divide_by_zero;
  int                 errors, pending, accepted_out;
  int                 idle_cycles = 0;
  int                 words_sent = 0;
  bit                 calm = 1'b0;  // no stalls or gaps in the closing stretch

  complex_arithmetic_unit dut (.*);

  cau_scoreboard chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall in random bursts, or not at all near the end.
  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Hold one word until the block accepts it; valid stays high unless the next word opens with a gap.
  task automatic send_word(op_t op, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    a_real   <= ar;
    a_imag   <= ai;
    b_real   <= br;
    b_imag   <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Pick an operand part: extremes, small values from -1024 to 1024, or anything.
  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4:    return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    op_t op;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each operation at the field extremes, and the zero divisor.
    for (int k = 0; k < 4; k++) begin
      op = op_t'(k);
      send_word(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_word(op, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
    end
    send_word(OP_DIV, 16'h1234, 16'hfedc, 16'h0000, 16'h0000);
    send_word(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_DIV, 16'h7fff, 16'h0000, 16'h0001, 16'h0000);
    send_word(OP_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
    send_word(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);

    // Drain before random traffic: sender waits for every expected word.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 100) calm = 1'b1;
      op = op_t'($urandom_range(0, 3));
      if (op == OP_DIV && $urandom_range(0, 15) == 0)
        send_word(op, pick_part(), pick_part(), 16'h0000, 16'h0000);
      else
        send_word(op, pick_part(), pick_part(), pick_part(), pick_part());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);

    $display("Sent %0d words over all four operations, %0d results checked,", words_sent,
             accepted_out);
    $display("with saturation, zero divisors and random stalls on both sides.");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
